### design/salp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salp_pkg
// Shared types and constants for the sensor ascii line parser.
// ----------------------------------------------------------------------------
package salp_pkg;

  localparam int LineDepthDef = 16;
  localparam int ReadingW     = 26;
  localparam int NumDigits    = 6;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChM     = 8'h6D;

  // digit weights per line position, percent mode skips positions 2 and 5
  localparam logic signed [ReadingW-1:0] PctWeight [NumDigits] = '{
    26'sd1000, 26'sd100, 26'sd0, 26'sd10, 26'sd1, 26'sd0
  };
  localparam logic signed [ReadingW-1:0] PpmWeight [NumDigits] = '{
    26'sd100000, 26'sd10000, 26'sd1000, 26'sd100, 26'sd10, 26'sd1
  };

  // snapshot of a completed line, handed to the decoder
  typedef struct packed {
    logic [NumDigits-1:0][7:0] lead_bytes;
    logic                      unit_ppm;
    logic                      overflow;
  } salp_line_t;

endpackage
`default_nettype wire

### design/salp_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salp_decode
// Turns the leading bytes of a completed line into a signed decimal reading.
// ----------------------------------------------------------------------------
module salp_decode (
  input  wire salp_pkg::salp_line_t             line_i,
  output logic signed [salp_pkg::ReadingW-1:0]  reading_o
);

  logic signed [8:0]                    digit [salp_pkg::NumDigits];
  logic signed [salp_pkg::ReadingW-1:0] term  [salp_pkg::NumDigits];
  logic signed [salp_pkg::ReadingW-1:0] weight[salp_pkg::NumDigits];
  logic                                 skip  [salp_pkg::NumDigits];

  always_comb begin
    for (int i = 0; i < salp_pkg::NumDigits; i++) begin
      digit[i]  = $signed({1'b0, line_i.lead_bytes[i]}) - $signed({1'b0, salp_pkg::ChZero});
      weight[i] = line_i.unit_ppm ? salp_pkg::PpmWeight[i] : salp_pkg::PctWeight[i];
      // percent mode only drops a leading space, ppm drops any space digit
      skip[i]   = (line_i.lead_bytes[i] == salp_pkg::ChSpace) && (line_i.unit_ppm || i == 0);
      term[i]   = skip[i] ? '0 : salp_pkg::ReadingW'(salp_pkg::ReadingW'(digit[i]) * weight[i]);
    end
  end

  assign reading_o = (term[0] + term[1]) + (term[2] + term[3]) + (term[4] + term[5]);

endmodule
`default_nettype wire

### design/sensor_ascii_line_parser_core.sv
`default_nettype none
// an accepted LF loads the snapshot stage, whose decoded reading moves into the output register once that can advance
// throughput: one byte per cycle while in_stall_o is low; a stalled output holds one line in the snapshot stage
// input stall rises only when the snapshot stage is full and the full output register is stalled
// reset: async active low, clears line position, mode, overflow flag and leading bytes
// ----------------------------------------------------------------------------
// sensor_ascii_line_parser_core
// Collects serial bytes into lines and reports the decoded reading on CR LF.
// ----------------------------------------------------------------------------
module sensor_ascii_line_parser_core #(
  parameter int LINE_DEPTH = salp_pkg::LineDepthDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [7:0]                         rx_byte_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic signed [salp_pkg::ReadingW-1:0] reading_o,
  output logic                               unit_ppm_o,
  output logic                               line_overflow_o
);

  localparam int PosW = $clog2(LINE_DEPTH + 1);

  logic [PosW-1:0] wr_pos_q, wr_pos_d;
  logic            mode_q, mode_d;
  logic            ovf_q, ovf_d;
  logic [salp_pkg::NumDigits-1:0][7:0] lead_q, lead_d;
  logic [3:0][7:0] hist_q, hist_d;   // hist_q[k] is the byte k+1 places back

  logic                 snap_valid_q;
  salp_pkg::salp_line_t snap_q, snap_d;
  logic                 out_valid_q;
  logic signed [salp_pkg::ReadingW-1:0] reading_q, reading_d;
  logic                 unit_ppm_q, line_ovf_q;

  logic accept, full, line_end, pct_hit, ppm_hit, out_adv;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = snap_valid_q && !out_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (wr_pos_q == PosW'(LINE_DEPTH));

  assign line_end = (rx_byte_i == salp_pkg::ChLf) && (wr_pos_q >= PosW'(1)) &&
                    (hist_q[0] == salp_pkg::ChCr);
  assign pct_hit  = (wr_pos_q >= PosW'(3)) && (hist_q[2] == salp_pkg::ChSpace) &&
                    (hist_q[1] == salp_pkg::ChPct);
  assign ppm_hit  = (wr_pos_q >= PosW'(4)) && (hist_q[3] == salp_pkg::ChP) &&
                    (hist_q[2] == salp_pkg::ChP) && (hist_q[1] == salp_pkg::ChM);

  always_comb begin
    wr_pos_d = wr_pos_q;
    mode_d   = mode_q;
    ovf_d    = ovf_q;
    lead_d   = lead_q;
    hist_d   = hist_q;
    if (accept) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        for (int i = 0; i < salp_pkg::NumDigits; i++) begin
          if (wr_pos_q == PosW'(i)) begin
            lead_d[i] = rx_byte_i;
          end
        end
        hist_d   = {hist_q[2:0], rx_byte_i};
        wr_pos_d = wr_pos_q + PosW'(1);
      end
      if (line_end) begin
        if (ppm_hit) begin
          mode_d = 1'b1;
        end else if (pct_hit) begin
          mode_d = 1'b0;
        end
        wr_pos_d = '0;
        ovf_d    = 1'b0;
      end
    end
  end

  // snapshot of the line as it stands after the LF, so the next line can start at once
  always_comb begin
    snap_d.lead_bytes = lead_d;
    snap_d.unit_ppm   = ppm_hit ? 1'b1 : (pct_hit ? 1'b0 : mode_q);
    snap_d.overflow   = ovf_q || full;
  end

  salp_decode u_decode (
    .line_i    (snap_q),
    .reading_o (reading_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q     <= '0;
      mode_q       <= 1'b0;
      ovf_q        <= 1'b0;
      lead_q       <= '0;
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      wr_pos_q <= wr_pos_d;
      mode_q   <= mode_d;
      ovf_q    <= ovf_d;
      lead_q   <= lead_d;
      if (accept && line_end) begin
        snap_valid_q <= 1'b1;
      end else if (out_adv) begin
        snap_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= snap_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
    if (accept && line_end) begin
      snap_q <= snap_d;
    end
    if (out_adv && snap_valid_q) begin
      reading_q  <= reading_d;
      unit_ppm_q <= snap_q.unit_ppm;
      line_ovf_q <= snap_q.overflow;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reading_o       = reading_q;
  assign unit_ppm_o      = unit_ppm_q;
  assign line_overflow_o = line_ovf_q;

endmodule
`default_nettype wire

### design/salp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salp_checker
// Port level checks for the sensor ascii line parser, bound to the top level.
// ----------------------------------------------------------------------------
module salp_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_valid_i,
  input wire                                in_stall_o,
  input wire  [7:0]                         rx_byte_i,
  input wire                                out_valid_o,
  input wire                                out_stall_i,
  input wire signed [salp_pkg::ReadingW-1:0] reading_o,
  input wire                                unit_ppm_o,
  input wire                                line_overflow_o
);

  // stalled output transaction stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(reading_o) && $stable(unit_ppm_o) &&
                                   $stable(line_overflow_o))
    else $error("stalled output payload changed");

  // input only stalls when the output register is backed up
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a fresh result traces back to an accepted LF through the snapshot stage
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && rx_byte_i == salp_pkg::ChLf, 2))
    else $error("result without a preceding line end");

  // percent readings stay within the range that four weighted byte positions of any value can reach
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !unit_ppm_o |->
      reading_o >= -26'sd53328 && reading_o <= 26'sd229977)
    else $error("percent reading out of range");

endmodule

bind sensor_ascii_line_parser_core salp_checker u_salp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .rx_byte_i       (rx_byte_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .reading_o       (reading_o),
  .unit_ppm_o      (unit_ppm_o),
  .line_overflow_o (line_overflow_o)
);
`default_nettype wire

### tb/sensor_ascii_line_parser_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_ascii_line_parser_core_test
// Streams serial bytes into the line parser: a few hand-built lines, then
// random percent, ppm, plain, noise and overflowing lines. An internal line
// tracker predicts every reading and checks it against the output channel
// under random sender gaps and receiver stalls, then with neither.
// ----------------------------------------------------------------------------
module sensor_ascii_line_parser_core_test;
  import salp_pkg::*;

  localparam int LineDepth   = LineDepthDef;
  localparam int PhaseBytes  = 200;
  localparam int DrainCycles = 8;
  localparam int RunLimitNs  = 400000;
  localparam logic [7:0] ChDot = 8'h2E;

  typedef struct {
    logic [ReadingW-1:0] reading;
    logic                unit_ppm;
    logic                overflow;
  } line_result_t;

  class reading_tracker;
    logic [7:0]   line_store [LineDepth];
    int unsigned  fill;
    logic         ppm_mode;
    logic         dropped;
    line_result_t pending[$];
    int unsigned  fail_count;

    function new();
      foreach (line_store[i]) line_store[i] = '0;
      fill       = 0;
      ppm_mode   = 1'b0;
      dropped    = 1'b0;
      fail_count = 0;
    endfunction

    // positions before the start of the line never match
    function automatic bit byte_at(int unsigned lf_pos, int unsigned back, logic [7:0] want);
      if (lf_pos < back) return 1'b0;
      if (lf_pos - back >= LineDepth) return 1'b0;
      return line_store[lf_pos - back] == want;
    endfunction

    function automatic int digit(int unsigned pos);
      return int'(line_store[pos]) - int'(ChZero);
    endfunction

    function automatic int decode_line();
      int acc;
      int weight;
      acc = 0;
      if (!ppm_mode) begin
        if (line_store[0] != ChSpace) acc = digit(0) * 1000;
        acc += digit(1) * 100 + digit(3) * 10 + digit(4);
      end else begin
        weight = 100000;
        for (int i = 0; i < NumDigits; i++) begin
          if (line_store[i] != ChSpace) acc += digit(i) * weight;
          weight = weight / 10;
        end
      end
      return acc;
    endfunction

    function automatic void note_byte(logic [7:0] b);
      int unsigned  p;
      int           val;
      line_result_t r;
      p = fill;
      if (p >= LineDepth) begin
        p       = LineDepth;
        dropped = 1'b1;
      end else begin
        line_store[p] = b;
        fill          = p + 1;
      end
      if (b != ChLf || !byte_at(p, 1, ChCr)) return;
      if (byte_at(p, 3, ChSpace) && byte_at(p, 2, ChPct)) ppm_mode = 1'b0;
      if (byte_at(p, 4, ChP) && byte_at(p, 3, ChP) && byte_at(p, 2, ChM)) ppm_mode = 1'b1;
      val        = decode_line();
      r.reading  = val[ReadingW-1:0];
      r.unit_ppm = ppm_mode;
      r.overflow = dropped;
      pending.push_back(r);
      fill    = 0;
      dropped = 1'b0;
    endfunction

    function automatic void check_reading(logic [ReadingW-1:0] reading, logic unit_ppm,
                                          logic overflow);
      line_result_t want;
      if (pending.size() == 0) begin
        $error("reading %0d arrived with no completed line pending", $signed(reading));
        fail_count++;
        return;
      end
      want = pending.pop_front();
      if (reading !== want.reading) begin
        $error("reading: expected %0d, got %0d", $signed(want.reading), $signed(reading));
        fail_count++;
      end
      if (unit_ppm !== want.unit_ppm) begin
        $error("unit_ppm: expected %0b, got %0b", want.unit_ppm, unit_ppm);
        fail_count++;
      end
      if (overflow !== want.overflow) begin
        $error("line_overflow: expected %0b, got %0b", want.overflow, overflow);
        fail_count++;
      end
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic [7:0]                 rx_byte_i   = '0;
  logic                       out_stall_i = 1'b0;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic signed [ReadingW-1:0] reading_o;
  logic                       unit_ppm_o;
  logic                       line_overflow_o;

  int unsigned    tx_gap_pct  = 0;
  int unsigned    rx_hold_pct = 0;
  reading_tracker tracker     = new();

  sensor_ascii_line_parser_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .reading_o      (reading_o),
    .unit_ppm_o     (unit_ppm_o),
    .line_overflow_o(line_overflow_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_hold_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_reading(reading_o, unit_ppm_o, line_overflow_o);
    end
  end

  initial begin
    #RunLimitNs;
    $display("sensor_ascii_line_parser_core verification failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    // keep the last slot a CR so that a full line can still be closed by LF
    if (tracker.fill == LineDepth - 1) b = ChCr;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_byte(b);
  endtask

  task automatic send_seq(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  function automatic void add_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_digit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return ChZero + 8'($urandom_range(9));
    if (r < 90) return ChSpace;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_line(output int unsigned n);
    logic [7:0]  q[$];
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // percent line, e.g. "12.34 %"
      q.push_back(($urandom_range(3) == 0) ? ChSpace : rand_digit());
      q.push_back(rand_digit());
      q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : ChDot);
      q.push_back(rand_digit());
      q.push_back(rand_digit());
      q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : ChSpace);
      q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : ChPct);
      q.push_back(ChCr);
      q.push_back(ChLf);
    end else if (kind < 65) begin
      for (int i = 0; i < NumDigits; i++) q.push_back(rand_digit());
      q.push_back(ChP);
      q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : ChP);
      q.push_back(ChM);
      q.push_back(ChCr);
      q.push_back(ChLf);
    end else if (kind < 75) begin
      // no unit suffix, mode carries over
      repeat ($urandom_range(6)) q.push_back(rand_digit());
      q.push_back(ChCr);
      q.push_back(ChLf);
    end else if (kind < 88) begin
      repeat ($urandom_range(4, 1)) q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(20, 14)) q.push_back(8'($urandom_range(255)));
      q.push_back(ChCr);
      q.push_back(ChLf);
    end
    send_seq(q);
    n = q.size();
  endtask

  task automatic run_directed();
    logic [7:0] q[$];
    // bare CR LF right after reset decodes CR, LF and the cleared rest of the store
    q = {ChCr, ChLf};
    // LF as first byte is stored, then 0x00 and 0xFF, ppm suffix, line overruns
    q = {q, ChLf, 8'h00, 8'hFF};
    add_text(q, "123456789ppm");
    q = {q, ChCr, 8'hFF, ChLf};
    // percent with blank leading digit switches back from ppm
    add_text(q, " 9 %");
    q = {q, ChCr, ChLf};
    send_seq(q);
  endtask

  task automatic drain_readings();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_gap_pct  = 14;
          rx_hold_pct = 78;
        end
        1: begin
          tx_gap_pct  = 78;
          rx_hold_pct = 14;
        end
        default: begin
          tx_gap_pct  = 0;
          rx_hold_pct = 0;
        end
      endcase
      if (phase == 0) run_directed();
      sent = 0;
      while (sent < PhaseBytes) begin
        send_random_line(n);
        sent += n;
      end
      // sender holds off until every reading of the phase is out
      drain_readings();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.fail_count == 0 && tracker.pending.size() == 0) begin
      $display("sensor_ascii_line_parser_core verification clean");
    end else begin
      $display("sensor_ascii_line_parser_core verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/salp_pkg.sv
design/salp_decode.sv
design/sensor_ascii_line_parser_core.sv
design/salp_checker.sv
tb/sensor_ascii_line_parser_core_test.sv
